@@ sv/kdec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Key sequence decoder package: action codes, key codes and the lookup
// functions for single keys and multi-key sequences. No dependencies.
package kdec_pkg;

  localparam int unsigned KeyW    = 8;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned TmoW    = 16;
  localparam int unsigned ActW    = 5;

  localparam logic [TmoW-1:0] TimeoutRst = 16'd750;

  typedef enum logic [ActW-1:0] {
    ACT_NONE      = 5'd0,
    ACT_QUIT      = 5'd1,
    ACT_CANCEL    = 5'd2,
    ACT_UP        = 5'd3,
    ACT_DOWN      = 5'd4,
    ACT_LEFT      = 5'd5,
    ACT_RIGHT     = 5'd6,
    ACT_TOP       = 5'd7,
    ACT_BOTTOM    = 5'd8,
    ACT_HALF_UP   = 5'd9,
    ACT_HALF_DOWN = 5'd10,
    ACT_SEARCH    = 5'd11,
    ACT_NEXT_MAT  = 5'd12,
    ACT_PREV_MAT  = 5'd13,
    ACT_SELECT    = 5'd14,
    ACT_EDIT      = 5'd15,
    ACT_RUN       = 5'd16,
    ACT_CHECK     = 5'd17,
    ACT_RESET     = 5'd18,
    ACT_MEDIA     = 5'd19,
    ACT_LESSON    = 5'd20,
    ACT_COURSE    = 5'd21,
    ACT_NEXT_BUF  = 5'd22,
    ACT_PREV_BUF  = 5'd23,
    ACT_HELP      = 5'd24
  } action_e;

  localparam logic [KeyW-1:0] KeyCtrlD  = 8'd4;
  localparam logic [KeyW-1:0] KeyLf     = 8'd10;
  localparam logic [KeyW-1:0] KeyCr     = 8'd13;
  localparam logic [KeyW-1:0] KeyCtrlU  = 8'd21;
  localparam logic [KeyW-1:0] KeyEsc    = 8'd27;
  localparam logic [KeyW-1:0] KeySpace  = 8'h20;
  localparam logic [KeyW-1:0] KeySlash  = 8'h2F;
  localparam logic [KeyW-1:0] KeyQmark  = 8'h3F;
  localparam logic [KeyW-1:0] KeyUpG    = 8'h47;
  localparam logic [KeyW-1:0] KeyUpN    = 8'h4E;
  localparam logic [KeyW-1:0] KeyUpT    = 8'h54;
  localparam logic [KeyW-1:0] KeyLBrack = 8'h5B;
  localparam logic [KeyW-1:0] KeyRBrack = 8'h5D;
  localparam logic [KeyW-1:0] KeyB      = 8'h62;
  localparam logic [KeyW-1:0] KeyC      = 8'h63;
  localparam logic [KeyW-1:0] KeyE      = 8'h65;
  localparam logic [KeyW-1:0] KeyG      = 8'h67;
  localparam logic [KeyW-1:0] KeyH      = 8'h68;
  localparam logic [KeyW-1:0] KeyJ      = 8'h6A;
  localparam logic [KeyW-1:0] KeyK      = 8'h6B;
  localparam logic [KeyW-1:0] KeyL      = 8'h6C;
  localparam logic [KeyW-1:0] KeyM      = 8'h6D;
  localparam logic [KeyW-1:0] KeyN      = 8'h6E;
  localparam logic [KeyW-1:0] KeyQ      = 8'h71;
  localparam logic [KeyW-1:0] KeyR      = 8'h72;
  localparam logic [KeyW-1:0] KeyT      = 8'h74;
  localparam logic [KeyW-1:0] KeyX      = 8'h78;

  // Keys that open a multi-key sequence.
  function automatic logic is_prefix_start(input logic [KeyW-1:0] k);
    return (k == KeyG) || (k == KeyRBrack) || (k == KeyLBrack) || (k == KeySpace);
  endfunction

  function automatic action_e single_act(input logic [KeyW-1:0] k);
    action_e a;
    case (k)
      KeyH:     a = ACT_LEFT;
      KeyJ:     a = ACT_DOWN;
      KeyK:     a = ACT_UP;
      KeyL:     a = ACT_RIGHT;
      KeyUpG:   a = ACT_BOTTOM;
      KeyCtrlD: a = ACT_HALF_DOWN;
      KeyCtrlU: a = ACT_HALF_UP;
      KeySlash: a = ACT_SEARCH;
      KeyN:     a = ACT_NEXT_MAT;
      KeyUpN:   a = ACT_PREV_MAT;
      KeyE:     a = ACT_EDIT;
      KeyLf:    a = ACT_SELECT;
      KeyCr:    a = ACT_SELECT;
      KeyQmark: a = ACT_HELP;
      KeyQ:     a = ACT_QUIT;
      default:  a = ACT_NONE;
    endcase
    return a;
  endfunction

  // Two-key sequences; ACT_NONE when there is no exact match.
  function automatic action_e seq2_act(input logic [KeyW-1:0] k0,
                                       input logic [KeyW-1:0] k1);
    action_e a;
    a = ACT_NONE;
    if (k0 == KeyG) begin
      if (k1 == KeyG)      a = ACT_TOP;
      else if (k1 == KeyT) a = ACT_NEXT_BUF;
      else if (k1 == KeyUpT) a = ACT_PREV_BUF;
    end else if (k0 == KeyRBrack && k1 == KeyB) begin
      a = ACT_NEXT_BUF;
    end else if (k0 == KeyLBrack && k1 == KeyB) begin
      a = ACT_PREV_BUF;
    end else if (k0 == KeySpace) begin
      case (k1)
        KeyR:     a = ACT_RUN;
        KeyT:     a = ACT_CHECK;
        KeyX:     a = ACT_RESET;
        KeyM:     a = ACT_MEDIA;
        KeyQmark: a = ACT_HELP;
        default:  a = ACT_NONE;
      endcase
    end
    return a;
  endfunction

  // Three-key sequences; ACT_NONE when there is no exact match.
  function automatic action_e seq3_act(input logic [KeyW-1:0] k0,
                                       input logic [KeyW-1:0] k1,
                                       input logic [KeyW-1:0] k2);
    action_e a;
    a = ACT_NONE;
    if (k0 == KeySpace && k1 == KeyL) begin
      if (k2 == KeyL)      a = ACT_LESSON;
      else if (k2 == KeyC) a = ACT_COURSE;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

@@ sv/kdec_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels of the key sequence decoder: key events in, actions out.
// Depends on kdec_pkg for field widths.
interface kdec_key_if
  import kdec_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [KeyW-1:0]         key;
  logic signed [TimeW-1:0] now_ms;

  modport source (output valid, key, now_ms, input ready);
  modport sink   (input valid, key, now_ms, output ready);
endinterface

interface kdec_act_if
  import kdec_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;

  modport source (output valid, action, input ready);
  modport sink   (input valid, action, output ready);
endinterface
`default_nettype wire

@@ sv/key_sequence_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Key sequence decoder: one action code per key event.
// Each key is held in the input register, then its action in the result register.
// One key per cycle unless act_o stalls. Timeout check: one 64-bit subtract and compare.
// Reset: normal mode, no pending keys, timeout 750 ms; no clearing pass.
// Depends on kdec_pkg and the channel interfaces in kdec_if.sv.
module key_sequence_decoder_core
  import kdec_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  kdec_key_if.sink             key_i,
  kdec_act_if.source           act_o,
  input  wire logic            cfg_we_i,
  input  wire logic [TmoW-1:0] cfg_wdata_i
);

  logic                    s1_valid_q;
  logic [KeyW-1:0]         s1_key_q;
  logic [TimeW-1:0]        s1_now_q;
  logic                    out_valid_q;
  action_e                 action_q, action_d;
  logic [TmoW-1:0]         timeout_q;
  logic                    search_q, search_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [KeyW-1:0]         k0_q, k0_d, k1_q, k1_d;
  logic [TimeW-1:0]        start_q, start_d;

  logic                    advance;
  logic [TimeW-1:0]        elapsed;
  logic                    expired;
  logic [1:0]              cnt_eff;
  action_e                 seq_a;

  assign advance     = s1_valid_q && (!out_valid_q || act_o.ready);
  assign key_i.ready = !s1_valid_q || advance;
  assign act_o.valid = out_valid_q;
  assign act_o.action = action_q;

  assign elapsed = s1_now_q - start_q;
  // Negative elapsed time never expires.
  assign expired = (cnt_q != 2'd0) && !elapsed[TimeW-1]
                   && (elapsed > {{(TimeW-TmoW){1'b0}}, timeout_q});
  assign cnt_eff = expired ? 2'd0 : cnt_q;

  always_comb begin
    action_d = ACT_NONE;
    search_d = search_q;
    cnt_d    = cnt_eff;
    k0_d     = k0_q;
    k1_d     = k1_q;
    start_d  = start_q;
    seq_a    = ACT_NONE;
    if (s1_key_q == KeyEsc) begin
      cnt_d    = 2'd0;
      search_d = 1'b0;
      action_d = ACT_CANCEL;
    end else if (search_q) begin
      if (s1_key_q == KeyLf || s1_key_q == KeyCr) begin
        search_d = 1'b0;
        action_d = ACT_SELECT;
      end
    end else if (cnt_eff == 2'd1) begin
      seq_a    = seq2_act(k0_q, s1_key_q);
      action_d = seq_a;
      // Only " l" stays a live prefix after two keys.
      if (seq_a == ACT_NONE && k0_q == KeySpace && s1_key_q == KeyL) begin
        k1_d  = s1_key_q;
        cnt_d = 2'd2;
      end else begin
        cnt_d = 2'd0;
      end
    end else if (cnt_eff != 2'd0) begin
      action_d = seq3_act(k0_q, k1_q, s1_key_q);
      cnt_d    = 2'd0;
    end else if (is_prefix_start(s1_key_q)) begin
      k0_d    = s1_key_q;
      cnt_d   = 2'd1;
      start_d = s1_now_q;
    end else begin
      action_d = single_act(s1_key_q);
      if (s1_key_q == KeySlash) begin
        search_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TimeoutRst;
      search_q    <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (key_i.ready) begin
        s1_valid_q <= key_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (act_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (advance) begin
        search_q <= search_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // Payload registers: hold until the next transfer.
  always_ff @(posedge clk_i) begin
    if (key_i.ready && key_i.valid) begin
      s1_key_q <= key_i.key;
      s1_now_q <= key_i.now_ms;
    end
    if (advance) begin
      action_q <= action_d;
      k0_q     <= k0_d;
      k1_q     <= k1_d;
      start_q  <= start_d;
    end
  end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for key_sequence_decoder_core: drives key events over the
// valid/ready channel and predicts each action with its own decoder model.
// Depends on kdec_pkg and the channel interfaces in kdec_if.sv.
module testbench
  import kdec_pkg::*;
();

  localparam int StallLimit = 1000;
  localparam int NumSeq     = 12;
  localparam int NumSingle  = 15;
  localparam logic [NumSingle*KeyW-1:0] SingleKeys = {
    KeyH, KeyJ, KeyK, KeyL, KeyUpG, KeyCtrlD, KeyCtrlU, KeySlash,
    KeyN, KeyUpN, KeyE, KeyLf, KeyCr, KeyQmark, KeyQ
  };
  localparam logic [TimeW-1:0] TimeMin = 64'h8000_0000_0000_0000;
  localparam logic [TimeW-1:0] TimeMax = 64'h7FFF_FFFF_FFFF_FFFF;

  // Decoder model plus the queue of actions still owed by the block.
  class action_scoreboard;
    logic [TmoW-1:0]  timeout_ms;
    bit               search_on;
    int               held_cnt;
    logic [KeyW-1:0]  held_keys [2];
    logic [TimeW-1:0] held_since;
    action_e          due_q [$];
    logic [3*KeyW-1:0] seq_keys [NumSeq];
    int               seq_len [NumSeq];
    action_e          seq_act [NumSeq];
    int               seq_n;

    function new();
      timeout_ms   = TimeoutRst;
      search_on    = 1'b0;
      held_cnt     = 0;
      held_keys[0] = '0;
      held_keys[1] = '0;
      held_since   = '0;
      seq_n        = 0;
      add_seq(KeyG, KeyG, 8'h00, 2, ACT_TOP);
      add_seq(KeyG, KeyT, 8'h00, 2, ACT_NEXT_BUF);
      add_seq(KeyG, KeyUpT, 8'h00, 2, ACT_PREV_BUF);
      add_seq(KeyRBrack, KeyB, 8'h00, 2, ACT_NEXT_BUF);
      add_seq(KeyLBrack, KeyB, 8'h00, 2, ACT_PREV_BUF);
      add_seq(KeySpace, KeyL, KeyL, 3, ACT_LESSON);
      add_seq(KeySpace, KeyL, KeyC, 3, ACT_COURSE);
      add_seq(KeySpace, KeyR, 8'h00, 2, ACT_RUN);
      add_seq(KeySpace, KeyT, 8'h00, 2, ACT_CHECK);
      add_seq(KeySpace, KeyX, 8'h00, 2, ACT_RESET);
      add_seq(KeySpace, KeyM, 8'h00, 2, ACT_MEDIA);
      add_seq(KeySpace, KeyQmark, 8'h00, 2, ACT_HELP);
    endfunction

    function void add_seq(logic [KeyW-1:0] k0, logic [KeyW-1:0] k1,
                          logic [KeyW-1:0] k2, int len, action_e act);
      seq_keys[seq_n] = {k0, k1, k2};
      seq_len[seq_n]  = len;
      seq_act[seq_n]  = act;
      seq_n++;
    endfunction

    function void drop_held();
      held_cnt   = 0;
      held_since = '0;
    endfunction

    // Compare the first n keys only; exact asks for a table entry of length n.
    function bit seq_hit(logic [3*KeyW-1:0] keys, int n, bit exact, output action_e act);
      logic [3*KeyW-1:0] mask;
      mask = {(3*KeyW){1'b1}} << (KeyW * (3 - n));
      act  = ACT_NONE;
      for (int i = 0; i < NumSeq; i++) begin
        if ((exact ? seq_len[i] == n : seq_len[i] >= n) &&
            ((seq_keys[i] ^ keys) & mask) == '0) begin
          act = seq_act[i];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function action_e decode_key(logic [KeyW-1:0] k, logic [TimeW-1:0] t);
      logic [TimeW-1:0]  elapsed;
      logic [3*KeyW-1:0] seq_buf;
      action_e           act;
      int                n;
      // A negative elapsed time never expires the pending keys.
      if (held_cnt > 0) begin
        elapsed = t - held_since;
        if (!elapsed[TimeW-1] && elapsed > {{(TimeW-TmoW){1'b0}}, timeout_ms}) drop_held();
      end
      if (k == KeyEsc) begin
        drop_held();
        search_on = 1'b0;
        return ACT_CANCEL;
      end
      if (search_on) begin
        if (k == KeyLf || k == KeyCr) begin
          search_on = 1'b0;
          return ACT_SELECT;
        end
        return ACT_NONE;
      end
      if (held_cnt > 0) begin
        n       = held_cnt + 1;
        seq_buf = {held_keys[0], held_keys[1], 8'h00};
        seq_buf[3*KeyW-1-KeyW*(n-1) -: KeyW] = k;
        if (seq_hit(seq_buf, n, 1'b1, act)) begin
          drop_held();
          return act;
        end
        if (n < 3 && seq_hit(seq_buf, n, 1'b0, act)) begin
          held_keys[n-1] = k;
          held_cnt       = n;
        end else begin
          drop_held();
        end
        return ACT_NONE;
      end
      if (k == KeyG || k == KeyRBrack || k == KeyLBrack || k == KeySpace) begin
        held_keys[0] = k;
        held_cnt     = 1;
        held_since   = t;
        return ACT_NONE;
      end
      case (k)
        KeyH:     return ACT_LEFT;
        KeyJ:     return ACT_DOWN;
        KeyK:     return ACT_UP;
        KeyL:     return ACT_RIGHT;
        KeyUpG:   return ACT_BOTTOM;
        KeyCtrlD: return ACT_HALF_DOWN;
        KeyCtrlU: return ACT_HALF_UP;
        KeySlash: begin
          search_on = 1'b1;
          return ACT_SEARCH;
        end
        KeyN:     return ACT_NEXT_MAT;
        KeyUpN:   return ACT_PREV_MAT;
        KeyE:     return ACT_EDIT;
        KeyLf,
        KeyCr:    return ACT_SELECT;
        KeyQmark: return ACT_HELP;
        KeyQ:     return ACT_QUIT;
        default:  return ACT_NONE;
      endcase
    endfunction

    function void note_key(logic [KeyW-1:0] k, logic [TimeW-1:0] t);
      due_q.push_back(decode_key(k, t));
    endfunction

    // Empty string when the action matches the oldest one owed.
    function string check_action(logic [ActW-1:0] got);
      action_e want;
      if (due_q.size() == 0) return $sformatf("unexpected action %0d", got);
      want = due_q.pop_front();
      if (got !== want)
        return $sformatf("action %0d, expected %0d (%s)", got, want, want.name());
      return "";
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TmoW-1:0]   cfg_wdata;
  kdec_key_if        key_if ();
  kdec_act_if        act_if ();

  action_scoreboard  sb = new();
  int                mismatches;
  int                keys_sent;
  int                burst_left;
  int                idle_cycles;
  logic [TimeW-1:0]  clock_ms;

  key_sequence_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .key_i       (key_if),
    .act_o       (act_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Mostly small steps, some around the timeout, some backward, some anywhere.
  function automatic logic [TimeW-1:0] tick_clock();
    int r;
    int tmo;
    r   = $urandom_range(0, 19);
    tmo = int'(sb.timeout_ms);
    if (r < 12) clock_ms += 64'($urandom_range(0, 300));
    else if (r < 16) clock_ms += 64'($urandom_range(0, 2 * tmo + 4));
    else if (r < 18) clock_ms -= 64'($urandom_range(1, 2000));
    else if (r == 18) clock_ms = {$urandom, $urandom};
    else clock_ms += 64'(tmo + $urandom_range(0, 1));
    return clock_ms;
  endfunction

  task automatic send_key(input logic [KeyW-1:0] k, input logic [TimeW-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        key_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    key_if.valid  <= 1'b1;
    key_if.key    <= k;
    key_if.now_ms <= t;
    @(posedge clk);
    while (!key_if.ready) @(posedge clk);
    sb.note_key(k, t);
    keys_sent++;
  endtask

  task automatic drain_actions();
    key_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TmoW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.timeout_ms = v;
  endtask

  task automatic directed_keys();
    send_key(KeyH, 64'd0);
    send_key(8'h00, TimeMin);
    send_key(8'hFF, TimeMax);
    // time going backward keeps the prefix alive
    send_key(KeyG, 64'd100);
    send_key(KeyG, 64'd50);
    // elapsed wraps from the top of the range to one
    send_key(KeySpace, TimeMax);
    send_key(KeyL, TimeMin);
    send_key(KeyL, TimeMin + 64'd1);
    // three keys that fall off the table
    send_key(KeySpace, 64'd1000);
    send_key(KeyL, 64'd1000);
    send_key(KeyX, 64'd1000);
    // one past the timeout expires, exactly at the timeout does not
    send_key(KeyRBrack, 64'd2000);
    send_key(KeyB, 64'd2751);
    send_key(KeyLBrack, 64'd3000);
    send_key(KeyB, 64'd3750);
    send_key(KeySlash, 64'd4000);
    send_key(KeyQ, 64'd4001);
    send_key(KeyG, 64'd4002);
    send_key(KeyCr, 64'd4003);
    send_key(KeySlash, 64'd4004);
    send_key(KeyLf, 64'd4005);
    send_key(KeyG, 64'd4006);
    send_key(KeyEsc, 64'd4007);
    send_key(KeyG, 64'd4008);
    send_key(KeyQ, 64'd4009);
    send_key(KeyQ, 64'd4010);
    clock_ms = 64'd10000;
  endtask

  task automatic random_keys(input int n_keys);
    int                target;
    int                kind;
    int                idx;
    int                len;
    logic [3*KeyW-1:0] seq;
    target = keys_sent + n_keys;
    while (keys_sent < target) begin
      kind = $urandom_range(0, 99);
      idx  = $urandom_range(0, NumSeq - 1);
      seq  = sb.seq_keys[idx];
      len  = sb.seq_len[idx];
      if (kind < 45) begin
        for (int j = 0; j < len; j++) send_key(seq[3*KeyW-1-KeyW*j -: KeyW], tick_clock());
      end else if (kind < 60) begin
        send_key(SingleKeys[KeyW*$urandom_range(0, NumSingle - 1) +: KeyW], tick_clock());
      end else if (kind < 70) begin
        send_key(KeySlash, tick_clock());
        repeat ($urandom_range(0, 3)) send_key(8'($urandom), tick_clock());
        case ($urandom_range(0, 2))
          0:       send_key(KeyCr, tick_clock());
          1:       send_key(KeyLf, tick_clock());
          default: send_key(KeyEsc, tick_clock());
        endcase
      end else if (kind < 80) begin
        // valid opener, then random bytes
        send_key(seq[3*KeyW-1 -: KeyW], tick_clock());
        send_key(8'($urandom), tick_clock());
        if ($urandom_range(0, 1) == 1) send_key(8'($urandom), tick_clock());
      end else if (kind < 88) begin
        for (int j = 0; j < len - 1; j++) send_key(seq[3*KeyW-1-KeyW*j -: KeyW], tick_clock());
        send_key(KeyEsc, tick_clock());
      end else begin
        send_key(8'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    int seg;
    int len;
    int mode;
    act_if.ready = 1'b0;
    seg = 0;
    @(posedge clk);
    forever begin
      seg++;
      if (seg % 5 == 0) begin
        // hold off long enough to back the decoder up into its input
        act_if.ready <= 1'b0;
        repeat ($urandom_range(60, 150)) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 120);
        for (int c = 0; c < len; c++) begin
          case (mode)
            0:       act_if.ready <= 1'b1;
            1:       act_if.ready <= ($urandom_range(0, 2) != 0);
            default: act_if.ready <= (c % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    string why;
    if (rst_n && act_if.valid && act_if.ready) begin
      why = sb.check_action(act_if.action);
      if (why != "") report_mismatch(why);
    end
  end

  always @(posedge clk) begin
    if ((key_if.valid && key_if.ready) || (act_if.valid && act_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles", StallLimit);
      $display("** key_sequence_decoder_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [TmoW-1:0] settings [5];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    key_if.valid  = 1'b0;
    key_if.key    = '0;
    key_if.now_ms = '0;
    mismatches    = 0;
    keys_sent     = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    clock_ms      = '0;
    settings[0] = 16'd0;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(2, 3000));
    settings[3] = 16'd1;
    settings[4] = TimeoutRst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_keys();
    drain_actions();
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      random_keys(265);
      drain_actions();
    end
    repeat (8) @(posedge clk);

    if (sb.outstanding() != 0)
      report_mismatch($sformatf("%0d actions never arrived", sb.outstanding()));
    if (mismatches == 0) begin
      $display("** key_sequence_decoder_core: PASSED **");
    end else begin
      $display("** key_sequence_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
